// File: rtl/soeb_pkg.sv
// ============================================================================
// soeb_pkg: shared types and constants for the segment box unit
// Holds the CORDIC angle table, the fixed-point constants, the register
// codes and the structs that travel between the cells of the chain.
// ============================================================================
package soeb_pkg;

    // default number of CORDIC steps in each chain
    localparam int unsigned DEF_CORDIC_STEPS = 24;

    // angles in Q30 radians, gain correction in Q28
    localparam logic signed [34:0] ANG_PI       = 35'sd3373259426;
    localparam logic signed [34:0] ANG_HALF_PI  = 35'sd1686629713;
    localparam logic [27:0]        INV_GAIN_Q28 = 28'd163008219;

    // floor(atan(2^-i) * 2^30)
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_EXTEND_ALONG = 1'b0,
        CFG_EXTEND_SIDE  = 1'b1
    } t_cfg_idx;

    // vectoring datapath: x, y grow by the CORDIC gain, z in Q30
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [34:0] z;
    } t_vec;

    // rotation datapath: cosine and sine in Q28, residual angle in Q30
    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [34:0] z;
    } t_rot;

    // side data that rides along with each segment
    typedef struct packed {
        logic signed [32:0] mx;    // start_x + end_x
        logic signed [32:0] my;    // start_y + end_y
        logic               zero;  // degenerate segment
        logic               neg;   // angle folded by pi
        logic [33:0]        hl;    // half-length, Q18.16
    } t_lane;

endpackage

// File: rtl/soeb_if.sv
// ============================================================================
// soeb_if: valid/ready channels of the segment box unit
// Segment channel carries two endpoints, box channel four corners.
// ============================================================================
interface soeb_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface soeb_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;

    modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, input ready);
    modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface

// File: rtl/soeb_vec_cell.sv
// ============================================================================
// soeb_vec_cell: one vectoring CORDIC step
// Drives y toward zero, accumulates the angle, hands on to the next cell.
// ============================================================================
module soeb_vec_cell #(
    parameter int unsigned K = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  soeb_pkg::t_vec  i_d,
    input  soeb_pkg::t_lane i_lane,
    output logic            o_valid,
    output soeb_pkg::t_vec  o_d,
    output soeb_pkg::t_lane o_lane
);
    import soeb_pkg::*;

    localparam int unsigned      L_SH   = K % 32;
    localparam logic signed [34:0] L_ATAN = $signed({3'b000, ATAN_Q30[L_SH]});

    logic  r_valid;
    t_vec  r_d, n_d;
    t_lane r_lane;

    // micro-rotation, direction from the sign of y
    always_comb begin
        if (i_d.y < 0) begin
            n_d.x = i_d.x - (i_d.y >>> L_SH);
            n_d.y = i_d.y + (i_d.x >>> L_SH);
            n_d.z = i_d.z - L_ATAN;
        end else begin
            n_d.x = i_d.x + (i_d.y >>> L_SH);
            n_d.y = i_d.y - (i_d.x >>> L_SH);
            n_d.z = i_d.z + L_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= n_d;
            r_lane <= i_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_lane  = r_lane;

endmodule

// File: rtl/soeb_rot_cell.sv
// ============================================================================
// soeb_rot_cell: one rotation CORDIC step
// Turns (cos, sin) toward the target angle, hands on to the next cell.
// ============================================================================
module soeb_rot_cell #(
    parameter int unsigned K = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  soeb_pkg::t_rot  i_d,
    input  soeb_pkg::t_lane i_lane,
    output logic            o_valid,
    output soeb_pkg::t_rot  o_d,
    output soeb_pkg::t_lane o_lane
);
    import soeb_pkg::*;

    localparam int unsigned        L_SH   = K % 32;
    localparam logic signed [34:0] L_ATAN = $signed({3'b000, ATAN_Q30[L_SH]});

    logic  r_valid;
    t_rot  r_d, n_d;
    t_lane r_lane;

    // micro-rotation, direction from the sign of the residual angle
    always_comb begin
        if (i_d.z >= 0) begin
            n_d.c = i_d.c - (i_d.s >>> L_SH);
            n_d.s = i_d.s + (i_d.c >>> L_SH);
            n_d.z = i_d.z - L_ATAN;
        end else begin
            n_d.c = i_d.c + (i_d.s >>> L_SH);
            n_d.s = i_d.s - (i_d.c >>> L_SH);
            n_d.z = i_d.z + L_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= n_d;
            r_lane <= i_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_lane  = r_lane;

endmodule

// File: rtl/soeb_corner.sv
// ============================================================================
// soeb_corner: box corners from half sizes, cos/sin and midpoint
// Three stages: partial products, product sums, corner add with saturation.
// The last stage is the output register.
// ============================================================================
module soeb_corner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  soeb_pkg::t_rot     i_d,
    input  soeb_pkg::t_lane    i_lane,
    input  logic [30:0]        i_ext_side,
    output logic               o_valid,
    output logic signed [31:0] o_cx [4],
    output logic signed [31:0] o_cy [4]
);
    import soeb_pkg::*;

    localparam logic signed [67:0] L_HALF = 68'sd1 <<< 27;
    localparam logic signed [39:0] L_MAX  = 40'sd2147483647;
    localparam logic signed [39:0] L_MIN  = -40'sd2147483648;

    logic [2:0] r_valid;

    // stage 1: partial products
    logic signed [31:0] w_c, w_s, w_hw;
    logic signed [17:0] w_lo, w_hi;
    logic signed [49:0] r_lc, r_hc, r_ls, r_hs;
    logic signed [63:0] r_wc, r_ws;
    logic signed [32:0] r_mx1, r_my1;

    assign w_c  = i_lane.neg ? -i_d.c : i_d.c;
    assign w_s  = i_lane.neg ? -i_d.s : i_d.s;
    assign w_hw = $signed({1'b0, i_ext_side});
    assign w_lo = $signed({1'b0, i_lane.hl[16:0]});
    assign w_hi = $signed({1'b0, i_lane.hl[33:17]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lc  <= 50'(w_lo) * 50'(w_c);
            r_hc  <= 50'(w_hi) * 50'(w_c);
            r_ls  <= 50'(w_lo) * 50'(w_s);
            r_hs  <= 50'(w_hi) * 50'(w_s);
            r_wc  <= 64'(w_hw) * 64'(w_c);
            r_ws  <= 64'(w_hw) * 64'(w_s);
            r_mx1 <= i_lane.mx;
            r_my1 <= i_lane.my;
        end
    end

    // stage 2: p = hl*c, r = hl*s, q = hw*s, u = hw*c, midpoint in Q44
    logic signed [67:0] r_p, r_q, r_r, r_u, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= (68'(r_hc) <<< 17) + 68'(r_lc);
            r_r  <= (68'(r_hs) <<< 17) + 68'(r_ls);
            r_q  <= 68'(r_ws);
            r_u  <= 68'(r_wc);
            r_cx <= 68'(r_mx1) <<< 27;
            r_cy <= 68'(r_my1) <<< 27;
        end
    end

    // stage 3: corner offsets (-,-),(+,-),(+,+),(-,+), round and saturate
    logic signed [67:0] w_ox [4], w_oy [4];
    logic signed [31:0] n_cx [4], n_cy [4];
    logic signed [31:0] r_cxo [4], r_cyo [4];

    function automatic logic signed [31:0] sat_round(input logic signed [67:0] v);
        logic signed [39:0] t;
        t = 40'(v >>> 28);
        if (t > L_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (t < L_MIN) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    always_comb begin
        w_ox[0] = -r_p + r_q;  w_oy[0] = -r_r - r_u;
        w_ox[1] =  r_p + r_q;  w_oy[1] =  r_r - r_u;
        w_ox[2] =  r_p - r_q;  w_oy[2] =  r_r + r_u;
        w_ox[3] = -r_p - r_q;  w_oy[3] = -r_r + r_u;
        for (int n = 0; n < 4; n++) begin
            n_cx[n] = sat_round(r_cx + w_ox[n] + L_HALF);
            n_cy[n] = sat_round(r_cy + w_oy[n] + L_HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cxo <= n_cx;
            r_cyo <= n_cy;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    assign o_valid = r_valid[2];
    assign o_cx    = r_cxo;
    assign o_cy    = r_cyo;

endmodule

// File: rtl/segment_expanded_oriented_box_unit.sv
// ============================================================================
// segment_expanded_oriented_box_unit: oriented box around a line segment
// Throughput one segment per cycle, set by the two unrolled CORDIC cell
// chains, except while the pipeline holds.
// The whole pipeline holds while a finished box is not taken.
// Synchronous active-low reset clears all stage valid bits and both margins.
// ============================================================================
module segment_expanded_oriented_box_unit #(
    parameter int unsigned CORDIC_STEPS = soeb_pkg::DEF_CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    soeb_seg_if.sink            i_seg,
    soeb_box_if.source          o_box,
    input  logic                i_cfg_we,
    input  soeb_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [30:0]         i_cfg_wdata
);
    import soeb_pkg::*;

    // configuration registers
    logic [30:0] r_ext_along, r_ext_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_along <= '0;
            r_ext_side  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXTEND_ALONG: r_ext_along <= i_cfg_wdata;
                CFG_EXTEND_SIDE:  r_ext_side  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: move when the output register is free or drained
    logic w_en;
    assign w_en        = !o_box.valid || o_box.ready;
    assign i_seg.ready = w_en;

    // stage 0: differences, left half plane fold, midpoint sums
    logic signed [32:0] w_dx, w_dy;
    t_vec  n_v0;
    t_lane n_l0;

    assign w_dx = 33'(i_seg.end_x) - 33'(i_seg.start_x);
    assign w_dy = 33'(i_seg.end_y) - 33'(i_seg.start_y);

    always_comb begin
        n_l0      = '0;
        n_l0.mx   = 33'(i_seg.start_x) + 33'(i_seg.end_x);
        n_l0.my   = 33'(i_seg.start_y) + 33'(i_seg.end_y);
        n_l0.zero = (w_dx == '0) && (w_dy == '0);
        if (w_dx < 0) begin
            n_v0.x = -36'(w_dx);
            n_v0.y = -36'(w_dy);
            n_v0.z = (w_dy >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            n_v0.x = 36'(w_dx);
            n_v0.y = 36'(w_dy);
            n_v0.z = '0;
        end
    end

    logic [CORDIC_STEPS:0] w_vv;
    t_vec  w_vd [CORDIC_STEPS+1];
    t_lane w_vl [CORDIC_STEPS+1];
    logic  r_v0_valid;
    t_vec  r_v0_d;
    t_lane r_v0_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0_valid <= 1'b0;
        end else if (w_en) begin
            r_v0_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v0_d    <= n_v0;
            r_v0_lane <= n_l0;
        end
    end

    assign w_vv[0] = r_v0_valid;
    assign w_vd[0] = r_v0_d;
    assign w_vl[0] = r_v0_lane;

    // vectoring chain
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
        soeb_vec_cell #(.K(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vv[g]),
            .i_d     (w_vd[g]),
            .i_lane  (w_vl[g]),
            .o_valid (w_vv[g+1]),
            .o_d     (w_vd[g+1]),
            .o_lane  (w_vl[g+1])
        );
    end

    // prep stage: zero-length fix, fold angle into +-pi/2, length products
    logic signed [34:0] w_zv, n_pz;
    logic               n_pneg;
    logic [34:0]        w_xv;
    logic               r_p_valid, r_p_neg;
    logic signed [34:0] r_p_z;
    logic [45:0]        r_p_pl;
    logic [44:0]        r_p_ph;
    t_lane              r_p_lane;

    assign w_zv = w_vl[CORDIC_STEPS].zero ? '0 : w_vd[CORDIC_STEPS].z;
    assign w_xv = w_vd[CORDIC_STEPS].x[34:0];

    always_comb begin
        n_pz   = w_zv;
        n_pneg = 1'b0;
        if (w_zv > ANG_HALF_PI) begin
            n_pz   = w_zv - ANG_PI;
            n_pneg = 1'b1;
        end else if (w_zv < -ANG_HALF_PI) begin
            n_pz   = w_zv + ANG_PI;
            n_pneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_vv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_z    <= n_pz;
            r_p_neg  <= n_pneg;
            r_p_pl   <= 46'(w_xv[17:0]) * 46'(INV_GAIN_Q28);
            r_p_ph   <= 45'(w_xv[34:18]) * 45'(INV_GAIN_Q28);
            r_p_lane <= w_vl[CORDIC_STEPS];
        end
    end

    // length stage: half-length = round(x / gain / 2) + extend_along
    logic [63:0] w_len;
    logic [CORDIC_STEPS:0] w_rv;
    t_rot  w_rd [CORDIC_STEPS+1];
    t_lane w_rl [CORDIC_STEPS+1];
    t_lane n_l1;
    logic  r_r0_valid;
    t_rot  r_r0_d;
    t_lane r_r0_lane;

    assign w_len = 64'({r_p_ph, 18'b0}) + 64'(r_p_pl) + (64'd1 << 28);

    always_comb begin
        n_l1     = r_p_lane;
        n_l1.neg = r_p_neg;
        n_l1.hl  = 34'(w_len[63:29]) + 34'(r_ext_along);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0_valid <= 1'b0;
        end else if (w_en) begin
            r_r0_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r0_d.c  <= 32'($signed({1'b0, INV_GAIN_Q28}));
            r_r0_d.s  <= '0;
            r_r0_d.z  <= r_p_z;
            r_r0_lane <= n_l1;
        end
    end

    assign w_rv[0] = r_r0_valid;
    assign w_rd[0] = r_r0_d;
    assign w_rl[0] = r_r0_lane;

    // rotation chain
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        soeb_rot_cell #(.K(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rv[g]),
            .i_d     (w_rd[g]),
            .i_lane  (w_rl[g]),
            .o_valid (w_rv[g+1]),
            .o_d     (w_rd[g+1]),
            .o_lane  (w_rl[g+1])
        );
    end

    // corner math and output register
    logic signed [31:0] w_cx [4], w_cy [4];

    soeb_corner u_corner (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_rv[CORDIC_STEPS]),
        .i_d        (w_rd[CORDIC_STEPS]),
        .i_lane     (w_rl[CORDIC_STEPS]),
        .i_ext_side (r_ext_side),
        .o_valid    (o_box.valid),
        .o_cx       (w_cx),
        .o_cy       (w_cy)
    );

    assign o_box.corner0_x = w_cx[0];
    assign o_box.corner0_y = w_cy[0];
    assign o_box.corner1_x = w_cx[1];
    assign o_box.corner1_y = w_cy[1];
    assign o_box.corner2_x = w_cx[2];
    assign o_box.corner2_y = w_cy[2];
    assign o_box.corner3_x = w_cx[3];
    assign o_box.corner3_y = w_cy[3];

    // a stalled pipeline keeps its occupancy
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vv) && $stable(w_rv))
        else $error("vectoring or rotation chain moved while stalled");

    // a degenerate segment reaches rotation with angle 0 and no fold
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid && r_p_lane.zero |-> (r_p_z == '0) && !r_p_neg)
        else $error("zero-length segment got a nonzero angle");

    // half-length never falls below the along-axis margin
    a_hl_margin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rv[0] |-> (w_rl[0].hl >= 34'(r_ext_along)))
        else $error("half-length below extend_along");

endmodule

// File: dv/soeb_tb_if.sv
// ============================================================================
// soeb_tb_if: bench-side note for the segment box channels
// The channel interfaces come with the RTL (soeb_seg_if, soeb_box_if); this
// file holds the bench's types for one box and one segment transaction.
// ============================================================================
`timescale 1ns / 1ps

package soeb_tb_pkg;

    // one expected or observed box, corners in order 0..3, x then y
    typedef struct packed {
        logic signed [31:0] c0x;
        logic signed [31:0] c0y;
        logic signed [31:0] c1x;
        logic signed [31:0] c1y;
        logic signed [31:0] c2x;
        logic signed [31:0] c2y;
        logic signed [31:0] c3x;
        logic signed [31:0] c3y;
    } t_box;

    // one segment transaction
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } t_seg;

endpackage

// File: dv/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for segment_expanded_oriented_box_unit
// Drives segments over a valid/ready channel, predicts each box with a
// bit-exact CORDIC model or uses a given box, compares all eight corner
// coordinates in order. Runs directed corner cases, then random segments
// under several sender/receiver idling mixes and margin settings.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import soeb_pkg::*;
    import soeb_tb_pkg::*;

    localparam int STEPS      = 24;
    localparam int LATENCY    = 2 * STEPS + 6;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [30:0] i_cfg_wdata;

    soeb_seg_if seg_ch ();
    soeb_box_if box_ch ();

    segment_expanded_oriented_box_unit #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg      (seg_ch.sink),
        .o_box      (box_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // bench copy of the margins
    longint margin_along;
    longint margin_side;

    t_box   box_queue[$];
    int     fail_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint cycle_count;

    // floor shift right on a 64 bit value
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // bit-exact box prediction for one segment
    function automatic t_box predict_box(t_seg sg);
        longint sx, sy, ex, ey, dx, dy, x, y, z, t, hl, hw, c, s, p, q, r, u;
        longint cx, cy, ox, oy, atn;
        longint vals[8];
        int     sa[4];
        int     sb[4];
        bit     flip;
        t_box   b;
        sa = '{-1, 1, 1, -1};
        sb = '{-1, -1, 1, 1};
        sx = sg.sx; sy = sg.sy; ex = sg.ex; ey = sg.ey;
        dx = ex - sx;
        dy = ey - sy;
        flip = 0;
        // vectoring: angle and scaled length
        if (dx < 0) begin
            x = -dx; y = -dy;
            z = (dy >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
        end else begin
            x = dx; y = dy; z = 0;
        end
        for (int i = 0; i < STEPS; i++) begin
            atn = longint'(ATAN_Q30[i & 31]);
            if (y < 0) begin
                t = x - shr_floor(y, i & 31);
                y = y + shr_floor(x, i & 31);
                z -= atn;
            end else begin
                t = x + shr_floor(y, i & 31);
                y = y - shr_floor(x, i & 31);
                z += atn;
            end
            x = t;
        end
        if (dx == 0 && dy == 0) z = 0;
        hl = shr_floor(x * longint'(INV_GAIN_Q28) + (64'sd1 << 28), 29) + margin_along;
        hw = margin_side;
        // rotation: cosine and sine in Q28
        if (z > longint'(ANG_HALF_PI)) begin
            z -= longint'(ANG_PI); flip = 1;
        end else if (z < -longint'(ANG_HALF_PI)) begin
            z += longint'(ANG_PI); flip = 1;
        end
        c = longint'(INV_GAIN_Q28);
        s = 0;
        for (int i = 0; i < STEPS; i++) begin
            atn = longint'(ATAN_Q30[i & 31]);
            if (z >= 0) begin
                t = c - shr_floor(s, i & 31);
                s = s + shr_floor(c, i & 31);
                z -= atn;
            end else begin
                t = c + shr_floor(s, i & 31);
                s = s - shr_floor(c, i & 31);
                z += atn;
            end
            c = t;
        end
        if (flip) begin
            c = -c; s = -s;
        end
        p = hl * c; q = hw * s; r = hl * s; u = hw * c;
        cx = (sx + ex) * (64'sd1 << 27);
        cy = (sy + ey) * (64'sd1 << 27);
        for (int n = 0; n < 4; n++) begin
            ox = sa[n] * p - sb[n] * q;
            oy = sa[n] * r + sb[n] * u;
            vals[2*n]   = shr_floor(cx + ox + (64'sd1 << 27), 28);
            vals[2*n+1] = shr_floor(cy + oy + (64'sd1 << 27), 28);
        end
        b.c0x = clamp32(vals[0]); b.c0y = clamp32(vals[1]);
        b.c1x = clamp32(vals[2]); b.c1y = clamp32(vals[3]);
        b.c2x = clamp32(vals[4]); b.c2y = clamp32(vals[5]);
        b.c3x = clamp32(vals[6]); b.c3y = clamp32(vals[7]);
        return b;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall, changed at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) box_ch.ready <= 1'b0;
        else box_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic cmp(string nm, logic signed [31:0] e, logic signed [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0d, actual %0d", nm, e, a);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_box e;
        if (i_rst_n && box_ch.valid && box_ch.ready) begin
            if (box_queue.size() == 0) begin
                $error("box transaction with no expectation waiting");
                fail_count++;
            end else begin
                e = box_queue.pop_front();
                cmp("corner0_x", e.c0x, box_ch.corner0_x);
                cmp("corner0_y", e.c0y, box_ch.corner0_y);
                cmp("corner1_x", e.c1x, box_ch.corner1_x);
                cmp("corner1_y", e.c1y, box_ch.corner1_y);
                cmp("corner2_x", e.c2x, box_ch.corner2_x);
                cmp("corner2_y", e.c2y, box_ch.corner2_y);
                cmp("corner3_x", e.c3x, box_ch.corner3_x);
                cmp("corner3_y", e.c3y, box_ch.corner3_y);
            end
        end
    end

    // margin write while the pipeline is empty
    task automatic write_margin(t_cfg_idx idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_EXTEND_ALONG) margin_along = val;
        else margin_side = val;
    endtask

    // send one segment; valid stays up after acceptance so that the next
    // transaction can follow back to back, idle gaps and drain() drop it
    task automatic send_segment(t_seg sg, bit has_exp = 0, t_box exp_box = '0);
        t_box exp_next;
        while ($urandom_range(99) < send_idle_pct) begin
            seg_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= sg.sx;
        seg_ch.start_y <= sg.sy;
        seg_ch.end_x   <= sg.ex;
        seg_ch.end_y   <= sg.ey;
        do @(posedge i_clk); while (!seg_ch.ready);
        exp_next = has_exp ? exp_box : predict_box(sg);
        box_queue.insert(box_queue.size(), exp_next);
        @(negedge i_clk);
    endtask

    task automatic drain();
        seg_ch.valid <= 1'b0;
        while (box_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7FFFFFFF - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(32'h0FFFFFFF)) - 32'sh08000000;
        endcase
    endfunction

    function automatic logic [30:0] rand_margin();
        case ($urandom_range(3))
            0: return 31'h7FFFFFFF;
            1: return 31'h0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(32'h00FFFFFF));
        endcase
    endfunction

    // directed stimulus: sx, sy, ex, ey
    t_seg dir_tbl[$];
    t_box zero_box;

    initial begin
        t_seg sg;
        cycle_count = 0;
        fail_count  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        margin_along = 0;
        margin_side  = 0;
        zero_box = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_EXTEND_ALONG;
        i_cfg_wdata = '0;
        seg_ch.valid = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x = '0;
        seg_ch.end_y = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // after reset: degenerate segment at the origin gives all-zero corners
        send_segment('{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, zero_box);
        // saturation: both endpoints at the positive or negative extreme
        send_segment('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1,
                     '{8{32'sh7FFFFFFF}});
        send_segment('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 1,
                     '{8{32'sh80000000}});
        // directions: all octants, left half plane with dy sign both ways
        dir_tbl = {
            '{32'sd0, 32'sd0, 32'sh00010000, 32'sd0},
            '{32'sd0, 32'sd0, 32'sh00010000, 32'sh00010000},
            '{32'sd0, 32'sd0, 32'sd0, 32'sh00010000},
            '{32'sd0, 32'sd0, -32'sh00010000, 32'sh00010000},
            '{32'sd0, 32'sd0, -32'sh00010000, 32'sd0},
            '{32'sd0, 32'sd0, -32'sh00010000, -32'sh00010000},
            '{32'sd0, 32'sd0, 32'sd0, -32'sh00010000},
            '{32'sd0, 32'sd0, 32'sh00010000, -32'sh00010000},
            '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
            '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000},
            '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF},
            '{32'sh80000000, 32'sd0, 32'sh7FFFFFFF, 32'sd0},
            '{32'sd5, 32'sd7, 32'sd5, 32'sd7},
            '{32'sh12345678, -32'sh0ABCDEF0, -32'sh01020304, 32'sh0FEDCBA9}
        };
        foreach (dir_tbl[i]) send_segment(dir_tbl[i]);
        drain();

        // margins at the top extreme, then at moderate values, directed rows each time
        write_margin(CFG_EXTEND_ALONG, 31'h7FFFFFFF);
        write_margin(CFG_EXTEND_SIDE, 31'h7FFFFFFF);
        foreach (dir_tbl[i]) send_segment(dir_tbl[i]);
        drain();
        write_margin(CFG_EXTEND_ALONG, 31'h00010000);
        write_margin(CFG_EXTEND_SIDE, 31'h00008000);
        foreach (dir_tbl[i]) send_segment(dir_tbl[i]);

        // random part: idling phases, margins changed between phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // sender waits for every box before the phase change
            drain();
            write_margin(CFG_EXTEND_ALONG, rand_margin());
            write_margin(CFG_EXTEND_SIDE, rand_margin());
            for (int k = 0; k < 225; k++) begin
                sg.sx = rand_coord();
                sg.sy = rand_coord();
                if ($urandom_range(9) == 0) begin
                    sg.ex = sg.sx; sg.ey = sg.sy;
                end else begin
                    sg.ex = rand_coord(); sg.ey = rand_coord();
                end
                send_segment(sg);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
